FILE: sv/hafd_pkg.sv
// Shared types, constants and digit decode functions for the hex frame decoder.
package hafd_pkg;

	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 5;
	localparam int COUNT_W = 7;

	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
	localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;
	localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

	localparam logic [CHAR_W-1:0] START_RESET  = 8'd60;
	localparam logic [CHAR_W-1:0] END_RESET    = 8'd62;
	localparam logic [CHAR_W-1:0] TYPE_RESET   = 8'd1;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_START_MARKER  = 2'd0;
	localparam logic [1:0] REG_END_MARKER    = 2'd1;
	localparam logic [1:0] REG_ACCEPTED_TYPE = 2'd2;

	localparam logic RK_PAYLOAD = 1'b0;
	localparam logic RK_HALT    = 1'b1;

	typedef enum logic [1:0] {
		PH_STANDBY = 2'd0,
		PH_TYPE    = 2'd1,
		PH_ONGOING = 2'd2
	} phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] start_marker;
		logic [CHAR_W-1:0] end_marker;
		logic [CHAR_W-1:0] accepted_type;
	} cfg_t;

	typedef struct packed {
		logic               result_kind;
		logic [CHAR_W-1:0]  payload_byte;
		logic [INDEX_W-1:0] byte_index;
	} result_t;

	function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			return c - CASE_DIFF;
		end
		return c;
	endfunction

	// Codes from 'A' upward (after uppercasing) map from 'A', all lower codes from '0', both wrapping mod 256.
	function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] u;
		u = to_upper(c);
		if (u >= CH_UPPER_A) begin
			return u - CH_UPPER_A + LETTER_OFS;
		end
		return u - CH_ZERO;
	endfunction

endpackage

FILE: sv/hafd_in_if.sv
// Input channel carrying one received character per item.
interface hafd_in_if import hafd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: sv/hafd_out_if.sv
// Output channel carrying one decoded payload byte or halt item.
interface hafd_out_if import hafd_pkg::*;;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [CHAR_W-1:0]  payload_byte;
	logic [INDEX_W-1:0] byte_index;

	modport source (output valid, output result_kind, output payload_byte,
		output byte_index, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input byte_index, output ready);
endinterface

FILE: sv/hafd_cfg.sv
// APB register file holding the frame markers and the accepted type.
module hafd_cfg import hafd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker  <= START_RESET;
			cfg_q.end_marker    <= END_RESET;
			cfg_q.accepted_type <= TYPE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_MARKER:  cfg_q.start_marker  <= pwdata[CHAR_W-1:0];
				REG_END_MARKER:    cfg_q.end_marker    <= pwdata[CHAR_W-1:0];
				REG_ACCEPTED_TYPE: cfg_q.accepted_type <= pwdata[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_MARKER:  prdata = {24'd0, cfg_q.start_marker};
			REG_END_MARKER:    prdata = {24'd0, cfg_q.end_marker};
			REG_ACCEPTED_TYPE: prdata = {24'd0, cfg_q.accepted_type};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

FILE: sv/hafd_core.sv
// Frame decoder datapath: input register, frame state and result register.
module hafd_core import hafd_pkg::*; #(
	parameter int MAX_CHARS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] in_rx,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           out_res
);

	localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_CHARS);

	logic              valid_s1;
	logic [CHAR_W-1:0] rx_s1;

	phase_t             phase_q, phase_d;
	logic [CHAR_W-1:0]  pend_q, pend_d;
	logic               held_q, held_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               type_ok_q, type_ok_d;
	logic [INDEX_W-1:0] idx_q, idx_d;

	logic    res_valid_q;
	result_t res_q, res_d;
	logic    emit;
	logic    out_free;
	logic    proc;

	logic [CHAR_W-1:0] upper_c;
	logic [CHAR_W-1:0] hi_val;
	logic [CHAR_W-1:0] lo_val;
	logic              char_ok;
	logic              halt;

	assign out_free  = !res_valid_q || out_ready;
	assign proc      = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign out_valid = res_valid_q;
	assign out_res   = res_q;

	assign upper_c = to_upper(rx_s1);
	assign hi_val  = digit_value(pend_q);
	assign lo_val  = digit_value(rx_s1);
	// A character whose uppercase form matches either marker also counts as valid.
	assign char_ok = (upper_c >= CH_ZERO && upper_c <= CH_NINE) ||
		(upper_c >= CH_UPPER_A && upper_c <= CH_UPPER_F) ||
		upper_c == cfg.start_marker || upper_c == cfg.end_marker;
	assign halt = rx_s1 == cfg.end_marker || !type_ok_q || !char_ok || count_q >= MaxCount;

	always_comb begin
		phase_d   = phase_q;
		pend_d    = pend_q;
		held_d    = held_q;
		count_d   = count_q;
		type_ok_d = type_ok_q;
		idx_d     = idx_q;
		emit      = 1'b0;
		res_d     = '0;
		case (phase_q)
			PH_TYPE: begin
				type_ok_d = digit_value(rx_s1) == cfg.accepted_type;
				phase_d   = PH_ONGOING;
			end
			PH_ONGOING: begin
				if (halt) begin
					phase_d   = PH_STANDBY;
					pend_d    = '0;
					held_d    = 1'b0;
					count_d   = '0;
					type_ok_d = 1'b0;
					idx_d     = '0;
					emit      = 1'b1;
					res_d.result_kind = RK_HALT;
				end else begin
					count_d = count_q + COUNT_W'(1);
					if (!held_q) begin
						pend_d = rx_s1;
						held_d = 1'b1;
					end else begin
						emit = 1'b1;
						res_d.result_kind  = RK_PAYLOAD;
						// The low digit is ORed in at full width, as a marker may decode above 15.
						res_d.payload_byte = {hi_val[3:0], 4'b0000} | lo_val;
						res_d.byte_index   = idx_q;
						idx_d  = idx_q + INDEX_W'(1);
						pend_d = '0;
						held_d = 1'b0;
					end
				end
			end
			default: begin
				phase_d = (rx_s1 == cfg.start_marker) ? PH_TYPE : PH_STANDBY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= in_rx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STANDBY;
			pend_q    <= '0;
			held_q    <= 1'b0;
			count_q   <= '0;
			type_ok_q <= 1'b0;
			idx_q     <= '0;
		end else if (proc) begin
			phase_q   <= phase_d;
			pend_q    <= pend_d;
			held_q    <= held_d;
			count_q   <= count_d;
			type_ok_q <= type_ok_d;
			idx_q     <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc) begin
			res_valid_q <= emit;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			res_q <= res_d;
		end
	end

endmodule

FILE: sv/hex_ascii_frame_decoder.sv
// Top level of the ASCII hex frame decoder with its APB register port.
//
//   channel   direction  handshake        payload
//   in_ch     sink       valid / ready    rx_byte
//   out_ch    source     valid / ready    result_kind, payload_byte, byte_index
//   apb       slave      psel / penable   paddr[3:0], pwdata, prdata (pready tied high)
//
// One character is accepted every cycle unless the output stalls; a result passes
// through the input register and then the result register before it appears on out_ch.
// Frame state is updated when a character moves from the input register on.
// A stalled output holds its item; the input register then fills and in_ch.ready drops.
// Reset clears the frame state and restores the register defaults at once.
module hex_ascii_frame_decoder import hafd_pkg::*; #(
	parameter int MAX_CHARS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	hafd_in_if.sink     in_ch,
	hafd_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg;
	result_t res;

	hafd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hafd_core #(
		.MAX_CHARS (MAX_CHARS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_rx     (in_ch.rx_byte),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_res   (res)
	);

	assign out_ch.result_kind  = res.result_kind;
	assign out_ch.payload_byte = res.payload_byte;
	assign out_ch.byte_index   = res.byte_index;

endmodule

FILE: tb/tb_hex_ascii_frame_decoder.sv
// Self-checking testbench for the hex ASCII frame decoder.
`timescale 1ns / 1ps

module tb_hex_ascii_frame_decoder import hafd_pkg::*;;

	localparam int MAX_CHARS     = 64;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 60;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int RANDOM_CHARS  = 55;

	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int SINK_ALWAYS  = 0;
	localparam int SINK_RANDOM  = 1;
	localparam int SINK_PATTERN = 2;

	localparam int CLOSE_END  = 0;
	localparam int CLOSE_NONE = 1;
	localparam int CLOSE_JUNK = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	hafd_in_if  in_if ();
	hafd_out_if out_if ();

	hex_ascii_frame_decoder #(.MAX_CHARS(MAX_CHARS)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_if),
		.out_ch  (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model of the frame decoder: registers and frame state.
	cfg_t             cfg_model;
	phase_t           fr_phase;
	logic [7:0]       fr_hi_char;
	logic             fr_hi_held;
	logic [6:0]       fr_count;
	logic             fr_type_ok;
	logic [4:0]       fr_index;

	result_t due_results[$];
	int      error_count = 0;
	int      chars_sent = 0;

	// Source and sink behavior.
	int         sink_mode = SINK_ALWAYS;
	logic [15:0] sink_pat = 16'hFFFF;
	logic [3:0] sink_cyc = '0;
	int         hold_requests = 0;
	int         holds_done = 0;
	int         hold_left = 0;
	bit         src_bursty = 1'b0;
	int         burst_left = 0;

	initial begin
		in_if.valid = 1'b0;
		in_if.rx_byte = '0;
		out_if.ready = 1'b0;
	end

	function automatic logic [7:0] upcase8(input logic [7:0] c);
		if (c >= "a" && c <= "z") begin
			return c - 8'h20;
		end
		return c;
	endfunction

	// Upcased codes from 'A' upward count up from ten at 'A', all lower codes from '0', both modulo 256.
	function automatic logic [7:0] hex_value(input logic [7:0] c);
		logic [7:0] u;
		u = upcase8(c);
		if (u >= "A") begin
			return u - 8'h37;
		end
		return u - 8'h30;
	endfunction

	function automatic logic char_ok(input logic [7:0] c);
		logic [7:0] u;
		u = upcase8(c);
		return (u >= "0" && u <= "9") || (u >= "A" && u <= "F") ||
			u == cfg_model.start_marker || u == cfg_model.end_marker;
	endfunction

	function automatic void clear_frame_model();
		fr_phase = PH_STANDBY;
		fr_hi_char = '0;
		fr_hi_held = 1'b0;
		fr_count = '0;
		fr_type_ok = 1'b0;
		fr_index = '0;
	endfunction

	function automatic void set_register(input logic [1:0] idx, input logic [7:0] value);
		case (idx)
			REG_START_MARKER: cfg_model.start_marker = value;
			REG_END_MARKER: cfg_model.end_marker = value;
			REG_ACCEPTED_TYPE: cfg_model.accepted_type = value;
			default: ;
		endcase
	endfunction

	// Advances the frame state by one character; returns 1 when a result is due.
	function automatic logic decode_char(input logic [7:0] c, output result_t r);
		logic [7:0] hi_v;
		logic [7:0] lo_v;
		r = '0;
		case (fr_phase)
			PH_TYPE: begin
				fr_type_ok = (hex_value(c) == cfg_model.accepted_type);
				fr_phase = PH_ONGOING;
				return 1'b0;
			end
			PH_ONGOING: begin
				if (c == cfg_model.end_marker || !fr_type_ok || !char_ok(c) ||
						fr_count >= MAX_CHARS) begin
					clear_frame_model();
					r.result_kind = RK_HALT;
					return 1'b1;
				end
				fr_count = fr_count + 7'd1;
				if (!fr_hi_held) begin
					fr_hi_char = c;
					fr_hi_held = 1'b1;
					return 1'b0;
				end
				hi_v = hex_value(fr_hi_char);
				lo_v = hex_value(c);
				r.result_kind = RK_PAYLOAD;
				r.payload_byte = {hi_v[3:0], 4'h0} | lo_v;
				r.byte_index = fr_index;
				fr_index = fr_index + 5'd1;
				fr_hi_char = '0;
				fr_hi_held = 1'b0;
				return 1'b1;
			end
			default: begin
				fr_phase = (c == cfg_model.start_marker) ? PH_TYPE : PH_STANDBY;
				return 1'b0;
			end
		endcase
	endfunction

	// Picks at random a character whose digit value equals t; bit 8 flags success.
	function automatic logic [8:0] type_char_for(input logic [7:0] t);
		int hits;
		int pick;
		int n;
		hits = 0;
		for (int i = 0; i < 256; i++) begin
			if (hex_value(8'(i)) == t) begin
				hits++;
			end
		end
		if (hits == 0) begin
			return 9'h000;
		end
		pick = $urandom_range(0, hits - 1);
		n = 0;
		for (int i = 0; i < 256; i++) begin
			if (hex_value(8'(i)) == t) begin
				if (n == pick) begin
					return {1'b1, 8'(i)};
				end
				n++;
			end
		end
		return 9'h000;
	endfunction

	function automatic logic [7:0] random_hex_char();
		int k;
		logic [7:0] c;
		k = $urandom_range(0, 15);
		if (k < 10) begin
			c = 8'h30 + 8'(k);
		end else begin
			c = 8'h41 + 8'(k - 10);
			if ($urandom_range(0, 1) == 1) begin
				c = c + 8'h20;
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("%0t ERROR %s", $time, what);
		end
	endtask

	// Compares each result item with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result with none due: kind %0d byte %02h index %0d",
					out_if.result_kind, out_if.payload_byte, out_if.byte_index));
			end else begin
				want = due_results.pop_front();
				if (out_if.result_kind !== want.result_kind) begin
					report_mismatch($sformatf("result_kind %0d, predicted %0d",
						out_if.result_kind, want.result_kind));
				end
				if (out_if.payload_byte !== want.payload_byte) begin
					report_mismatch($sformatf("payload_byte %02h, predicted %02h",
						out_if.payload_byte, want.payload_byte));
				end
				if (out_if.byte_index !== want.byte_index) begin
					report_mismatch($sformatf("byte_index %0d, predicted %0d",
						out_if.byte_index, want.byte_index));
				end
			end
		end
	end

	// Receiver: a requested long hold takes priority over the current stall mode.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			out_if.ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
				SINK_PATTERN: out_if.ready <= sink_pat[sink_cyc];
				default: out_if.ready <= 1'b1;
			endcase
		end
		sink_cyc <= sink_cyc + 4'd1;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_char(input logic [7:0] c);
		result_t r;
		int gap;
		in_if.valid <= 1'b1;
		in_if.rx_byte <= c;
		@(posedge clk);
		while (!in_if.ready) begin
			@(posedge clk);
		end
		if (decode_char(c, r)) begin
			due_results.push_back(r);
		end
		chars_sent++;
		if (src_bursty) begin
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(1, 7);
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Stops offering items and waits until every predicted result has come out.
	task automatic drain_results();
		in_if.valid <= 1'b0;
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		set_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [1:0] idx, input logic [7:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata[7:0] !== want) begin
			report_mismatch($sformatf("register %0d reads %02h, predicted %02h",
				idx, prdata[7:0], want));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_markers(input logic [7:0] s, input logic [7:0] e, input logic [7:0] t);
		drain_results();
		apb_write(REG_START_MARKER, s);
		apb_write(REG_END_MARKER, e);
		apb_write(REG_ACCEPTED_TYPE, t);
		apb_read_check(REG_START_MARKER, cfg_model.start_marker);
		apb_read_check(REG_END_MARKER, cfg_model.end_marker);
		apb_read_check(REG_ACCEPTED_TYPE, cfg_model.accepted_type);
	endtask

	// Sends one frame of n data characters; messy frames mix in markers and junk.
	task automatic send_frame(input int n, input bit good_type, input bit messy,
			input int close_kind);
		logic [8:0] tc;
		logic [7:0] c;
		int r;
		send_char(cfg_model.start_marker);
		tc = type_char_for(cfg_model.accepted_type);
		if (good_type && tc[8]) begin
			send_char(tc[7:0]);
		end else begin
			send_char(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < n; i++) begin
			c = random_hex_char();
			if (messy) begin
				r = $urandom_range(0, 29);
				if (r == 0) begin
					c = cfg_model.start_marker;
				end else if (r == 1) begin
					// For an uppercase letter end marker this is its lowercase form, which passes as a digit.
					c = upcase8(cfg_model.end_marker) + 8'h20;
				end else if (r == 2) begin
					c = 8'($urandom_range(0, 255));
				end
			end
			send_char(c);
		end
		case (close_kind)
			CLOSE_END: send_char(cfg_model.end_marker);
			CLOSE_JUNK: send_char(8'($urandom_range(0, 255)));
			default: ;
		endcase
	endtask

	task automatic test_register_defaults();
		apb_read_check(REG_START_MARKER, START_RESET);
		apb_read_check(REG_END_MARKER, END_RESET);
		apb_read_check(REG_ACCEPTED_TYPE, TYPE_RESET);
	endtask

	// Short frames on the reset markers: extremes, wrong type, bad character,
	// a start marker used as a digit and an odd digit count before the end.
	task automatic test_directed_frames();
		string s;
		s = "><100FfaB><212<11G<1<3><17>";
		sink_mode = SINK_ALWAYS;
		src_bursty = 1'b0;
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
		drain_results();
	endtask

	task automatic test_config_extremes();
		logic [7:0] starts[4];
		logic [7:0] ends[4];
		logic [7:0] types[4];
		starts = '{8'h00, 8'hFF, "Z", "."};
		ends = '{8'hFF, 8'h00, "G", "a"};
		types = '{8'h00, 8'hFF, 8'h0F, 8'h23};
		sink_mode = SINK_RANDOM;
		src_bursty = 1'b1;
		for (int k = 0; k < 4; k++) begin
			set_markers(starts[k], ends[k], types[k]);
			for (int f = 0; f < 4; f++) begin
				send_frame($urandom_range(0, 10), f != 3, 1'b1, CLOSE_END);
			end
		end
		// The spare address must leave every register as it is.
		drain_results();
		apb_write(REG_SPARE, 8'hA5);
		apb_read_check(REG_START_MARKER, cfg_model.start_marker);
		apb_read_check(REG_END_MARKER, cfg_model.end_marker);
		apb_read_check(REG_ACCEPTED_TYPE, cfg_model.accepted_type);
	endtask

	// Frames that run into the character limit, with and without an end marker.
	task automatic test_frame_limit();
		set_markers(START_RESET, END_RESET, TYPE_RESET);
		sink_mode = SINK_ALWAYS;
		src_bursty = 1'b0;
		send_frame(MAX_CHARS + 1, 1'b1, 1'b0, CLOSE_NONE);
		send_frame(MAX_CHARS, 1'b1, 1'b0, CLOSE_END);
		sink_mode = SINK_PATTERN;
		sink_pat = 16'hB6D5;
		src_bursty = 1'b1;
		send_frame(MAX_CHARS - 1, 1'b1, 1'b0, CLOSE_END);
		send_frame(MAX_CHARS + 4, 1'b1, 1'b0, CLOSE_JUNK);
		drain_results();
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls;
	// later the sender pauses mid-frame until every result is out.
	task automatic test_output_hold();
		sink_mode = SINK_ALWAYS;
		src_bursty = 1'b0;
		hold_requests++;
		send_frame(40, 1'b1, 1'b0, CLOSE_END);
		send_frame(10, 1'b1, 1'b0, CLOSE_NONE);
		drain_results();
		sink_mode = SINK_RANDOM;
		for (int i = 0; i < 10; i++) begin
			send_char(random_hex_char());
		end
		send_char(cfg_model.end_marker);
		drain_results();
	endtask

	task automatic test_random_traffic();
		int phase_start;
		int r;
		int close_kind;
		int n;
		logic [7:0] t;
		for (int p = 0; p < 5; p++) begin
			t = hex_value(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 4) == 0) begin
				t = 8'($urandom_range(0, 255));
			end
			set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), t);
			sink_mode = $urandom_range(SINK_ALWAYS, SINK_PATTERN);
			sink_pat = 16'($urandom_range(0, 65535)) | 16'h0001;
			src_bursty = ($urandom_range(0, 3) != 0);
			phase_start = chars_sent;
			while (chars_sent - phase_start < RANDOM_CHARS) begin
				repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)));
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
				r = $urandom_range(0, 9);
				close_kind = (r < 7) ? CLOSE_END : ((r < 9) ? CLOSE_JUNK : CLOSE_NONE);
				send_frame(n, $urandom_range(0, 7) != 0, $urandom_range(0, 2) == 0,
					close_kind);
			end
		end
		drain_results();
	endtask

	initial begin
		cfg_model.start_marker = START_RESET;
		cfg_model.end_marker = END_RESET;
		cfg_model.accepted_type = TYPE_RESET;
		clear_frame_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_defaults();
		test_directed_frames();
		test_config_extremes();
		test_frame_limit();
		test_output_hold();
		test_random_traffic();

		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
